// ===== rtl/core/sha_pkg.sv =====
// Shared types, constants and functions for the SHA-256 byte stream hasher.
// No dependencies; the hasher module imports this package.
`default_nettype none

package sha_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Throughput: one byte request per cycle while a block is filling; a full block then
// stalls input through one load, 64 rounds on one round unit and one fold.
// End of message: one padding pass of 3 to 16 word writes and one compression, or two
// passes and two compressions when the length spills; then eight digest words, one per
// cycle when the sink is ready. The round unit sets rate.
// Reset (synchronous, active low) loads the initial hash and clears length and fill.
`default_nettype none

module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_in   i_in,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out
);

    // Control state.
    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;      // bytes in the current block
    logic [5:0]  r_t, n_t;            // round counter
    logic [3:0]  r_pidx, n_pidx;      // padding word pointer
    logic        r_pfirst, n_pfirst;  // next padding word holds the 0x80 marker
    logic        r_extra, n_extra;    // marker block cannot hold the length
    logic        r_pend, n_pend;      // padding still owed for this message
    logic        r_last, n_last;      // running compression is the final one
    logic [2:0]  r_oidx, n_oidx;
    logic [63:0] r_len, n_len;
    logic [31:0] r_h [8];
    logic [31:0] n_h [8];

    // Datapath state.
    logic [31:0] r_acc, n_acc;        // partial word being assembled
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];

    // Block buffer: sixteen big-endian words.
    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic        in_fire, out_fire;
    logic [1:0]  lane;
    logic [31:0] acc_base, acc_new, pad_word, w_cur, w_sched, t1, t2;
    logic [5:0]  fill_next;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    assign o_out = '{digest_word: r_h[r_oidx],
                     word_number: r_oidx,
                     last_word:   (r_oidx == 3'd7)};

    // Bytes land big-endian in the word; a fresh word starts from zero so unused
    // lanes are already clear when padding begins.
    assign lane     = r_fill[1:0];
    assign acc_base = (lane == 2'd0) ? 32'd0 : r_acc;
    assign acc_new  = acc_base | ({24'd0, i_in.data_byte} << (5'd24 - {lane, 3'd0}));
    assign pad_word = acc_base | ({24'd0, PAD_BYTE} << (5'd24 - {lane, 3'd0}));
    assign fill_next = i_in.has_byte ? r_fill + 6'd1 : r_fill;

    // The first sixteen schedule words come from the buffer, the rest from the window.
    assign w_sched = sml_sig1(r_w[14]) + r_w[9] + sml_sig0(r_w[1]) + r_w[0];
    assign w_cur   = (r_t[5:4] == 2'd0) ? ram_rdata : w_sched;
    assign t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_ROUND[r_t] + w_cur;
    assign t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_COLLECT;
            r_fill   <= '0;
            r_t      <= '0;
            r_pidx   <= '0;
            r_pfirst <= 1'b0;
            r_extra  <= 1'b0;
            r_pend   <= 1'b0;
            r_last   <= 1'b0;
            r_oidx   <= '0;
            r_len    <= '0;
            r_h      <= H_INIT;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_t      <= n_t;
            r_pidx   <= n_pidx;
            r_pfirst <= n_pfirst;
            r_extra  <= n_extra;
            r_pend   <= n_pend;
            r_last   <= n_last;
            r_oidx   <= n_oidx;
            r_len    <= n_len;
            r_h      <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_v   <= n_v;
        r_w   <= n_w;
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_t      = r_t;
        n_pidx   = r_pidx;
        n_pfirst = r_pfirst;
        n_extra  = r_extra;
        n_pend   = r_pend;
        n_last   = r_last;
        n_oidx   = r_oidx;
        n_len    = r_len;
        n_h      = r_h;
        n_acc    = r_acc;
        n_v      = r_v;
        n_w      = r_w;
        ram_we    = 1'b0;
        ram_waddr = r_fill[5:2];
        ram_wdata = acc_new;
        ram_raddr = r_t[3:0] + 4'd1;

        unique case (r_state)
            S_COLLECT: begin
                if (in_fire) begin
                    if (i_in.has_byte) begin
                        n_acc  = acc_new;
                        n_fill = fill_next;
                        n_len  = r_len + 64'd8;
                        ram_we = (lane == 2'd3);
                    end
                    if (i_in.end_of_message) begin
                        n_pend   = 1'b1;
                        n_pidx   = fill_next[5:2];
                        n_pfirst = 1'b1;
                        n_extra  = (fill_next >= 6'd56);
                        n_state  = S_PAD;
                    end
                    // A completed block is compressed first; padding then starts
                    // on the empty buffer.
                    if (i_in.has_byte && r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_pidx;
                if (r_pfirst) begin
                    ram_wdata = pad_word;
                end else if (!r_extra && r_pidx == 4'd14) begin
                    ram_wdata = r_len[63:32];
                end else if (!r_extra && r_pidx == 4'd15) begin
                    ram_wdata = r_len[31:0];
                end else begin
                    ram_wdata = 32'd0;
                end
                n_pfirst = 1'b0;
                n_pidx   = r_pidx + 4'd1;
                if (r_pidx == 4'd15) begin
                    n_state = S_LOAD;
                    if (r_extra) begin
                        n_extra = 1'b0;
                    end else begin
                        n_pend = 1'b0;
                        n_last = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                ram_raddr = 4'd0;
                n_v       = r_h;
                n_t       = '0;
                n_state   = S_ROUND;
            end
            S_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_cur;
                n_v[0] = t1 + t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                n_t = r_t + 6'd1;
                if (r_t == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_fill = '0;
                if (r_last) begin
                    n_last  = 1'b0;
                    n_oidx  = '0;
                    n_state = S_EMIT;
                end else if (r_pend) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_COLLECT;
                end
            end
            S_EMIT: begin
                if (out_fire) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_h     = H_INIT;
                        n_len   = '0;
                        n_fill  = '0;
                        n_state = S_COLLECT;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // Input and output never open at once: digests stall new requests.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output channels both open");

    // Rounds advance by one every cycle until the last.
    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_t != 6'd63) |=> (r_state == S_ROUND && r_t == $past(r_t) + 6'd1))
        else $error("round counter skipped");

    // Digest words leave in order, back to back with the sink.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_out.last_word) |=>
            (o_out_valid && o_out.word_number == $past(o_out.word_number) + 3'd1))
        else $error("digest word order broken");

endmodule

`default_nettype wire
